@@ src/mcpe_pkg.sv @@
// Shared constants, codes and controller/datapath handshake types for the
// motor command packet encoder. No dependencies.
package mcpe_pkg;

  localparam int MotorCountDef = 6;

  localparam int PosW = 5;

  // Command codes as they arrive on the input stream
  localparam logic [1:0] CMD_SPEED     = 2'd0;
  localparam logic [1:0] CMD_PID       = 2'd1;
  localparam logic [1:0] CMD_RESET_ENC = 2'd2;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_GAIN_P   = 2'd0;
  localparam logic [1:0] REG_GAIN_I   = 2'd1;
  localparam logic [1:0] REG_GAIN_D   = 2'd2;
  localparam logic [1:0] REG_MAX_RATE = 2'd3;

  localparam logic [31:0] GAIN_P_RST   = 32'h003F_0000;
  localparam logic [31:0] GAIN_I_RST   = 32'h0019_0000;
  localparam logic [31:0] GAIN_D_RST   = 32'h0069_0000;
  localparam logic [31:0] MAX_RATE_RST = 32'd20000;

  localparam logic [7:0] ADDR_BASE      = 8'd129;
  localparam logic [7:0] OP_SPEED_BASE  = 8'd35;
  localparam logic [7:0] OP_PID_BASE    = 8'd28;
  localparam logic [7:0] OP_RESET_ENC   = 8'd20;
  localparam logic [6:0] CSUM_MASK      = 7'h7F;

  // Position of the checksum byte in each packet kind
  localparam logic [PosW-1:0] LAST_POS_SPEED = 5'd6;
  localparam logic [PosW-1:0] LAST_POS_PID   = 5'd18;
  localparam logic [PosW-1:0] LAST_POS_RESET = 5'd2;

  typedef struct packed {
    logic            load_item;  // capture the accepted command, clear checksum
    logic            emit;       // put the byte at pos into the output register
    logic [PosW-1:0] pos;        // byte position within the packet
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being drained this cycle
    logic is_last;   // byte at pos is the checksum
  } dp_stat_t;

endpackage

@@ src/mcpe_ctrl.sv @@
// Controller for the motor command packet encoder: input handshake, item
// screening and byte sequencing. Depends on mcpe_pkg.
module mcpe_ctrl
  import mcpe_pkg::*;
#(
  parameter int MotorCount = MotorCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_command_i,
  input  logic [2:0] in_motor_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic            state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            accept;
  logic            item_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // unused command code and out-of-range motors are dropped silently
  assign item_ok    = (in_command_i != CMD_UNUSED) && (int'(in_motor_i) < MotorCount);

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    cmd_o.load_item = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.pos       = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && item_ok) begin
          cmd_o.load_item = 1'b1;
          pos_d           = '0;
          state_d         = ST_SEND;
        end
      end
      ST_SEND: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          pos_d      = pos_q + 5'd1;
          if (stat_i.is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

endmodule

@@ src/mcpe_dp.sv @@
// Datapath for the motor command packet encoder: config registers, held
// command, byte select, running checksum and output register. Depends on mcpe_pkg.
module mcpe_dp
  import mcpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  in_command_i,
  input  logic [2:0]  in_motor_i,
  input  logic [31:0] in_speed_i,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);

  logic [31:0] gain_p_q, gain_i_q, gain_d_q, max_rate_q;
  logic [1:0]  held_cmd_q;
  logic [2:0]  held_motor_q;
  logic [31:0] held_speed_q;
  logic [6:0]  csum_q, csum_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q;
  logic        last_q;

  logic [PosW-1:0] pos_off;
  logic [31:0]     word;
  logic [7:0]      data_byte;
  logic [7:0]      sel_byte;
  logic [PosW-1:0] last_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= GAIN_P_RST;
      gain_i_q   <= GAIN_I_RST;
      gain_d_q   <= GAIN_D_RST;
      max_rate_q <= MAX_RATE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_P:   gain_p_q   <= cfg_data_i;
        REG_GAIN_I:   gain_i_q   <= cfg_data_i;
        REG_GAIN_D:   gain_d_q   <= cfg_data_i;
        REG_MAX_RATE: max_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      held_cmd_q   <= in_command_i;
      held_motor_q <= in_motor_i;
      held_speed_q <= in_speed_i;
    end
  end

  // payload bytes start at position 2, four per word, MSB first
  assign pos_off = cmd_i.pos - 5'd2;

  always_comb begin
    case (pos_off[3:2])
      2'd0:    word = (held_cmd_q == CMD_SPEED) ? held_speed_q : gain_d_q;
      2'd1:    word = gain_p_q;
      2'd2:    word = gain_i_q;
      default: word = max_rate_q;
    endcase
    case (pos_off[1:0])
      2'd0:    data_byte = word[31:24];
      2'd1:    data_byte = word[23:16];
      2'd2:    data_byte = word[15:8];
      default: data_byte = word[7:0];
    endcase
  end

  always_comb begin
    case (held_cmd_q)
      CMD_SPEED: last_pos = LAST_POS_SPEED;
      CMD_PID:   last_pos = LAST_POS_PID;
      default:   last_pos = LAST_POS_RESET;
    endcase
  end

  always_comb begin
    if (cmd_i.pos == 5'd0) begin
      sel_byte = ADDR_BASE + {6'd0, held_motor_q[2:1]};
    end else if (cmd_i.pos == 5'd1) begin
      case (held_cmd_q)
        CMD_SPEED: sel_byte = OP_SPEED_BASE + {7'd0, held_motor_q[0]};
        CMD_PID:   sel_byte = OP_PID_BASE + {7'd0, held_motor_q[0]};
        default:   sel_byte = OP_RESET_ENC;
      endcase
    end else begin
      sel_byte = data_byte;
    end
  end

  assign stat_o.is_last  = (cmd_i.pos == last_pos);
  assign stat_o.out_free = !valid_q || out_ready_i;

  always_comb begin
    csum_d = csum_q;
    if (cmd_i.load_item) begin
      csum_d = '0;
    end else if (cmd_i.emit && !stat_o.is_last) begin
      csum_d = (csum_q + sel_byte[6:0]) & CSUM_MASK;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      csum_q  <= csum_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      byte_q <= stat_o.is_last ? {1'b0, csum_q} : sel_byte;
      last_q <= stat_o.is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

@@ src/motor_command_packet_encoder.sv @@
// Motor command packet encoder: one command in, one serial packet of bytes out.
// Top level; depends on mcpe_pkg, mcpe_ctrl and mcpe_dp.
//
// Usage:
//   s_axis: one command per transfer. tdata = {speed_value[31:0],
//   motor_index[2:0], command[1:0]} from bit 0, padded to 40 bits.
//   m_axis: one packet byte per transfer, tlast on the checksum byte.
//   cfg: register writes (0 gain_p, 1 gain_i, 2 gain_d, 3 max_pulse_rate),
//   always ready, to be issued while no packet is in flight.
//   Packets are 7 bytes (set speed), 19 (set PID) or 3 (reset encoders);
//   command code 3 and motors at or above MotorCount are taken and dropped.
// Timing:
//   The first byte is valid on m_axis once the command transfer has moved the
//   sequencer into its send state and the byte has reached the output register,
//   then one byte per cycle while m_axis_tready is high; between packets the
//   sequencer returns to idle, where the next command is taken.
//   s_axis_tready stays low while a packet is being sequenced and returns
//   high once the checksum byte is in the output register.
//   A low m_axis_tready holds the output byte and pauses the sequencer.
//   Reset clears the sequencer and output valid and restores the gain words
//   and pulse rate to their defaults.
module motor_command_packet_encoder
  import mcpe_pkg::*;
#(
  parameter int MotorCount = MotorCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // command[1:0], motor_index[4:2], speed_value[36:5]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tx_byte[7:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic [1:0]  in_command;
  logic [2:0]  in_motor;
  logic [31:0] in_speed;

  assign in_command  = s_axis_tdata[1:0];
  assign in_motor    = s_axis_tdata[4:2];
  assign in_speed    = s_axis_tdata[36:5];
  assign cfg_ready_o = 1'b1;

  mcpe_ctrl #(
    .MotorCount(MotorCount)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_command_i(in_command),
    .in_motor_i  (in_motor),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  mcpe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_command_i(in_command),
    .in_motor_i  (in_motor),
    .in_speed_i  (in_speed),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ src/mcpe_checker.sv @@
// Port-level checks for the motor command packet encoder, bound to the top.
// Depends on mcpe_pkg and motor_command_packet_encoder.
module mcpe_checker
  import mcpe_pkg::*;
#(
  parameter int MotorCount = MotorCountDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  logic in_xfer;
  logic item_ok;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign item_ok = (s_axis_tdata[1:0] != CMD_UNUSED) &&
                   (int'(s_axis_tdata[4:2]) < MotorCount);

  // a valid command starts a packet and blocks the input
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && item_ok |=> !s_axis_tready)
    else $error("input still ready after a valid command");

  // dropped commands leave the block idle
  a_idle_after_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !item_ok |=> s_axis_tready)
    else $error("input not ready after a dropped command");

  // checksum byte is 7 bits wide
  a_csum_7bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[7])
    else $error("checksum byte has bit 7 set");

  // stalled output byte holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

endmodule

bind motor_command_packet_encoder mcpe_checker #(
  .MotorCount(MotorCount)
) u_mcpe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

@@ dv/motor_command_packet_encoder_test.sv @@
// Self-checking testbench for motor_command_packet_encoder: predicts every packet byte
// and compares each m_axis transfer. Depends on mcpe_pkg and the encoder RTL.
`timescale 1ns / 1ps

module motor_command_packet_encoder_test;
  import mcpe_pkg::*;

  localparam logic [1:0] CmdUnused = CMD_UNUSED;
  localparam int SettleCycles = 6;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } pkt_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Gain words and max rate as the block should currently hold them
  logic [31:0] cur_gain_p = GAIN_P_RST;
  logic [31:0] cur_gain_i = GAIN_I_RST;
  logic [31:0] cur_gain_d = GAIN_D_RST;
  logic [31:0] cur_max_rate = MAX_RATE_RST;

  pkt_byte_t pending_bytes[$];
  int        mismatch_count = 0;
  bit        idle_en = 1'b1;
  int        stall_left = 0;

  motor_command_packet_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Expected packet for one command; unused codes and absent motors give none
  task automatic predict_packet(input logic [1:0] cmd, input logic [2:0] motor,
                                input logic [31:0] speed);
    logic [7:0]  body[$];
    logic [31:0] words[$];
    logic [6:0]  sum;
    if (cmd == CmdUnused || motor >= MotorCountDef) return;
    body.push_back(ADDR_BASE + 8'(motor >> 1));
    case (cmd)
      CMD_SPEED: begin
        body.push_back(OP_SPEED_BASE + 8'(motor[0]));
        words.push_back(speed);
      end
      CMD_PID: begin
        body.push_back(OP_PID_BASE + 8'(motor[0]));
        words = '{cur_gain_d, cur_gain_p, cur_gain_i, cur_max_rate};
      end
      default: body.push_back(OP_RESET_ENC);
    endcase
    foreach (words[w]) begin
      for (int b = 3; b >= 0; b--) body.push_back(words[w][8*b +: 8]);
    end
    sum = '0;
    foreach (body[k]) begin
      sum += body[k][6:0];
      pending_bytes.push_back('{value: body[k], last: 1'b0});
    end
    pending_bytes.push_back('{value: {1'b0, sum & CSUM_MASK}, last: 1'b1});
  endtask

  task automatic send_command(input logic [1:0] cmd, input logic [2:0] motor,
                              input logic [31:0] speed);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, speed, motor, cmd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_packet(cmd, motor, speed);
  endtask

  // Hold the input side until every expected byte is out, then let it settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_GAIN_P: cur_gain_p = value;
      REG_GAIN_I: cur_gain_i = value;
      REG_GAIN_D: cur_gain_d = value;
      default:    cur_max_rate = value;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mostly valid commands; a few unused codes and absent motors mixed in
  task automatic send_random_item(output bit counted);
    logic [1:0]  cmd;
    logic [2:0]  motor;
    int          pick;
    pick = $urandom_range(0, 99);
    cmd = (pick < 45) ? CMD_SPEED : (pick < 65) ? CMD_PID :
          (pick < 93) ? CMD_RESET_ENC : CmdUnused;
    motor = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(MotorCountDef, 7))
                                         : 3'($urandom_range(0, MotorCountDef - 1));
    send_command(cmd, motor, pick_word());
    counted = (cmd != CmdUnused) && (motor < MotorCountDef);
  endtask

  task automatic test_reset_defaults();
    send_command(CMD_PID, 3'd0, 32'h0);
    send_command(CMD_PID, 3'd5, 32'hFFFF_FFFF);
    send_command(CMD_SPEED, 3'd3, 32'h0000_4E20);
    send_command(CMD_RESET_ENC, 3'd4, 32'h0);
  endtask

  task automatic test_directed_items();
    send_command(CMD_SPEED, 3'd0, 32'h0000_0000);
    send_command(CMD_SPEED, 3'd1, 32'hFFFF_FFFF);
    send_command(CMD_SPEED, 3'd4, 32'h8000_0001);
    send_command(CMD_SPEED, 3'd5, 32'h7FFF_FFFE);
    send_command(CMD_SPEED, 3'd2, 32'h1234_5678);
    // speed field is carried but must not leak into these packets
    send_command(CMD_PID, 3'd2, 32'hA5A5_A5A5);
    send_command(CMD_RESET_ENC, 3'd5, 32'hFFFF_FFFF);
    send_command(CMD_RESET_ENC, 3'd0, 32'h0);
    send_command(CMD_RESET_ENC, 3'd3, 32'h5A5A_5A5A);
    // dropped: unused code, motors past the last one
    send_command(CmdUnused, 3'd0, 32'hFFFF_FFFF);
    send_command(CMD_SPEED, 3'd6, 32'h0000_0001);
    send_command(CMD_PID, 3'd7, 32'hFFFF_FFFF);
    send_command(CmdUnused, 3'd7, 32'h0);
    send_command(CMD_RESET_ENC, 3'd6, 32'h0);
    send_command(CMD_PID, 3'd1, 32'h0);
    send_command(CMD_SPEED, 3'd3, 32'h00FF_00FF);
  endtask

  task automatic test_gain_settings();
    logic [31:0] sets[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h7F7F_7F7F};
    foreach (sets[s]) begin
      wait_idle();
      write_reg(REG_GAIN_P, sets[s]);
      write_reg(REG_GAIN_I, ~sets[s]);
      write_reg(REG_GAIN_D, sets[s] ^ 32'h00FF_FF00);
      write_reg(REG_MAX_RATE, sets[s]);
      send_command(CMD_PID, 3'($urandom_range(0, MotorCountDef - 1)), $urandom());
      send_command(CMD_SPEED, 3'($urandom_range(0, MotorCountDef - 1)), sets[s]);
      send_command(CMD_PID, 3'($urandom_range(0, MotorCountDef - 1)), 32'h0);
    end
  endtask

  task automatic test_random_traffic();
    bit counted;
    int accepted;
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      idle_en = (phase < 4);
      write_reg(REG_GAIN_P, pick_word());
      write_reg(REG_GAIN_I, pick_word());
      write_reg(REG_GAIN_D, pick_word());
      write_reg(REG_MAX_RATE, pick_word());
      accepted = 0;
      while (accepted < 100) begin
        send_random_item(counted);
        if (counted) accepted++;
      end
    end
  endtask

  // Output side: random stall bursts while idling is enabled
  always @(negedge clk_i) begin
    if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 7);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pkt_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("unexpected byte", m_axis_tdata, 8'h00);
      end else begin
        want = pending_bytes.pop_front();
        if (m_axis_tdata !== want.value) report_mismatch("tdata", m_axis_tdata, want.value);
        if (m_axis_tlast !== want.last)
          report_mismatch("tlast", 8'(m_axis_tlast), 8'(want.last));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed_items();
    test_gain_settings();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("motor_command_packet_encoder_test OK");
    end else begin
      $display("motor_command_packet_encoder_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("motor_command_packet_encoder_test NOT OK");
    $finish;
  end

endmodule
